// File: hdl/nsi_pkg.sv
// ----------------------------------------------------------------------------
// nsi_pkg: shared types and constants of the non-uniform Simpson integrator
// Number formats, datapath widths, command codes and the front-to-back
// command record.
// ----------------------------------------------------------------------------
package nsi_pkg;

	localparam int FRAC_BITS = 16;
	// numerator scaling from 2*FRAC_BITS to 64 fractional bits
	localparam int SCALE_SH  = 2 * (32 - FRAC_BITS);
	localparam int TRAP_SH   = SCALE_SH - 1;
	localparam int TRAP_LIM  = 64 - SCALE_SH;

	localparam int X_W    = 32;
	localparam int ACC_W  = 64;
	localparam int MA_W   = 100;
	localparam int MB_W   = 36;
	localparam int MP_W   = MA_W + MB_W;
	localparam int T_W    = 66;
	localparam int NUM_W  = 134;
	localparam int DEN_W  = 67;
	localparam int DIVN_W = NUM_W + SCALE_SH;
	localparam int Q_W    = 64;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// operation of one kept sample
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_TRAP = 2'd1;
	localparam logic [1:0] OP_SIMP = 2'd2;

	// what to report at the end of a line
	localparam logic [1:0] END_ZERO = 2'd0;
	localparam logic [1:0] END_EVEN = 2'd1;
	localparam logic [1:0] END_HALF = 2'd2;

	typedef struct packed {
		logic [1:0]            op;
		logic                  odd_sum;
		logic                  last;
		logic [1:0]            end_kind;
		logic signed [X_W-1:0] x0;
		logic signed [X_W-1:0] f0;
		logic signed [X_W-1:0] x1;
		logic signed [X_W-1:0] f1;
		logic signed [X_W-1:0] x2;
		logic signed [X_W-1:0] f2;
	} cmd_t;

endpackage

// File: hdl/nsi_front.sv
// ----------------------------------------------------------------------------
// nsi_front: request intake and classification
// Keeps the last two kept samples and the sample count class, and turns each
// request into a command for the arithmetic back end.
// ----------------------------------------------------------------------------
module nsi_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [nsi_pkg::X_W-1:0] coord,
	input  logic signed [nsi_pkg::X_W-1:0] sample,
	input  logic                           last,
	output logic                           q_push,
	output nsi_pkg::cmd_t                  q_cmd,
	input  logic                           q_full
);

	localparam logic [1:0] CNT_ZERO = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_MANY = 2'd2;

	logic                           skip_q;
	logic                           dropped_q;
	logic [1:0]                     cnt_q;
	logic                           par_q;
	logic signed [nsi_pkg::X_W-1:0] x0_q, f0_q, x1_q, f1_q;
	logic                           fire, drop;

	assign in_stall = q_full;
	assign fire     = in_valid & ~q_full;
	assign drop     = skip_q & (cnt_q == CNT_ZERO) & ~dropped_q;
	assign q_push   = fire & (~drop | last);

	always_comb begin
		q_cmd.x0       = x0_q;
		q_cmd.f0       = f0_q;
		q_cmd.x1       = x1_q;
		q_cmd.f1       = f1_q;
		q_cmd.x2       = coord;
		q_cmd.f2       = sample;
		q_cmd.last     = last;
		q_cmd.odd_sum  = par_q;
		q_cmd.op       = nsi_pkg::OP_NONE;
		q_cmd.end_kind = nsi_pkg::END_ZERO;
		if (!drop) begin
			unique case (cnt_q)
				CNT_ZERO: q_cmd.op = nsi_pkg::OP_NONE;
				CNT_ONE:  q_cmd.op = nsi_pkg::OP_TRAP;
				default:  q_cmd.op = nsi_pkg::OP_SIMP;
			endcase
			if (par_q)
				q_cmd.end_kind = nsi_pkg::END_HALF;
			else if (cnt_q != CNT_ZERO)
				q_cmd.end_kind = nsi_pkg::END_EVEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q    <= 1'b0;
			dropped_q <= 1'b0;
			cnt_q     <= CNT_ZERO;
			par_q     <= 1'b0;
			x0_q      <= '0;
			f0_q      <= '0;
			x1_q      <= '0;
			f1_q      <= '0;
		end else begin
			if (cfg_wr_en)
				skip_q <= cfg_wr_data;
			if (fire) begin
				if (last) begin
					dropped_q <= 1'b0;
					cnt_q     <= CNT_ZERO;
					par_q     <= 1'b0;
					x0_q      <= '0;
					f0_q      <= '0;
					x1_q      <= '0;
					f1_q      <= '0;
				end else if (drop) begin
					dropped_q <= 1'b1;
				end else begin
					x0_q  <= x1_q;
					f0_q  <= f1_q;
					x1_q  <= coord;
					f1_q  <= sample;
					par_q <= ~par_q;
					cnt_q <= (cnt_q == CNT_ZERO) ? CNT_ONE : CNT_MANY;
				end
			end
		end
	end

endmodule

// File: hdl/nsi_queue.sv
// ----------------------------------------------------------------------------
// nsi_queue: command queue between front and back end
// Two-entry FIFO so that intake and arithmetic stall independently.
// ----------------------------------------------------------------------------
module nsi_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  nsi_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output nsi_pkg::cmd_t head,
	output logic          empty
);

	nsi_pkg::cmd_t                mem [nsi_pkg::QUEUE_DEPTH];
	logic [nsi_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [nsi_pkg::QCNT_W-1:0]   count_q;

	assign full  = (count_q == nsi_pkg::QCNT_W'(nsi_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: hdl/nsi_mul.sv
// ----------------------------------------------------------------------------
// nsi_mul: shared sequential multiplier
// Sign-magnitude shift-and-add, one multiplier bit per cycle, finishing as
// soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module nsi_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [nsi_pkg::MA_W-1:0] a,
	input  logic signed [nsi_pkg::MB_W-1:0] b,
	output logic                            done,
	output logic signed [nsi_pkg::MP_W-1:0] p
);

	logic [nsi_pkg::MA_W-1:0] a_mag;
	logic [nsi_pkg::MB_W-1:0] b_mag;
	logic [nsi_pkg::MP_W-1:0] acc_q, a_q;
	logic [nsi_pkg::MB_W-1:0] b_q;
	logic                     neg_q, run_q, done_q;

	assign a_mag = a[nsi_pkg::MA_W-1] ? nsi_pkg::MA_W'(-a) : nsi_pkg::MA_W'(a);
	assign b_mag = b[nsi_pkg::MB_W-1] ? nsi_pkg::MB_W'(-b) : nsi_pkg::MB_W'(b);
	assign done  = done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= nsi_pkg::MP_W'(a_mag);
			b_q   <= b_mag;
			neg_q <= a[nsi_pkg::MA_W-1] ^ b[nsi_pkg::MB_W-1];
		end else if (run_q) begin
			if (b_q == '0) begin
				p <= neg_q ? $signed(~acc_q + 1'b1) : $signed(acc_q);
			end else begin
				if (b_q[0])
					acc_q <= acc_q + a_q;
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && b_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

endmodule

// File: hdl/nsi_div.sv
// ----------------------------------------------------------------------------
// nsi_div: restoring divider for the Simpson term
// Unsigned, one quotient bit per cycle. Quotients that do not fit in 64 bits
// are caught up front and reported as overflow.
// ----------------------------------------------------------------------------
module nsi_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [nsi_pkg::DIVN_W-1:0]   n,
	input  logic [nsi_pkg::DEN_W-1:0]    d,
	output logic                         done,
	output logic [nsi_pkg::Q_W-1:0]      q,
	output logic                         ovf
);

	localparam int HI_W  = nsi_pkg::DIVN_W - nsi_pkg::Q_W;
	localparam int CNT_W = $clog2(nsi_pkg::Q_W + 1);

	logic [HI_W-1:0]              n_hi;
	logic [nsi_pkg::DEN_W-1:0]    r_q, d_q;
	logic [nsi_pkg::Q_W-1:0]      nl_q, q_q;
	logic [nsi_pkg::DEN_W:0]      r2;
	logic                         ge;
	logic [CNT_W-1:0]             cnt_q;
	logic                         run_q, done_q, ovf_q;

	assign n_hi = n[nsi_pkg::DIVN_W-1:nsi_pkg::Q_W];
	assign r2   = {r_q, nl_q[nsi_pkg::Q_W-1]};
	assign ge   = (r2 >= {1'b0, d_q});
	assign done = done_q;
	assign q    = q_q;
	assign ovf  = ovf_q;

	always_ff @(posedge clk) begin
		if (start) begin
			d_q  <= d;
			r_q  <= n_hi[nsi_pkg::DEN_W-1:0];
			nl_q <= n[nsi_pkg::Q_W-1:0];
			q_q  <= '0;
		end else if (run_q) begin
			r_q  <= ge ? nsi_pkg::DEN_W'(r2 - {1'b0, d_q}) : r2[nsi_pkg::DEN_W-1:0];
			q_q  <= {q_q[nsi_pkg::Q_W-2:0], ge};
			nl_q <= nl_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// quotient >= 2^64 exactly when n / 2^64 >= d
				if (n_hi >= HI_W'(d)) begin
					ovf_q  <= 1'b1;
					done_q <= 1'b1;
				end else begin
					ovf_q <= 1'b0;
					run_q <= 1'b1;
					cnt_q <= CNT_W'(nsi_pkg::Q_W);
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: hdl/nsi_back.sv
// ----------------------------------------------------------------------------
// nsi_back: arithmetic back end
// Sequencer over one shared multiplier and one divider: Simpson terms,
// trapezoids, the two saturating sums and the end-of-line result.
// ----------------------------------------------------------------------------
module nsi_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	input  nsi_pkg::cmd_t                    q_head,
	output logic                             q_pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [nsi_pkg::ACC_W-1:0] integral,
	output logic                             spacing_error
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_DEC      = 4'd1;
	localparam logic [3:0] ST_MUL_GO   = 4'd2;
	localparam logic [3:0] ST_MUL_WAIT = 4'd3;
	localparam logic [3:0] ST_DIV_GO   = 4'd4;
	localparam logic [3:0] ST_DIV_WAIT = 4'd5;
	localparam logic [3:0] ST_ACC      = 4'd6;
	localparam logic [3:0] ST_END      = 4'd7;
	localparam logic [3:0] ST_FIN1     = 4'd8;
	localparam logic [3:0] ST_FIN2     = 4'd9;
	localparam logic [3:0] ST_FIN3     = 4'd10;
	localparam logic [3:0] ST_FIN4     = 4'd11;
	localparam logic [3:0] ST_EMIT     = 4'd12;

	// multiplier steps
	localparam logic [3:0] SP_A1  = 4'd0;  // f0*h1
	localparam logic [3:0] SP_A2  = 4'd1;  // *(2h0-h1)
	localparam logic [3:0] SP_B1  = 4'd2;  // f1*s
	localparam logic [3:0] SP_B2  = 4'd3;  // *s
	localparam logic [3:0] SP_C1  = 4'd4;  // f2*h0
	localparam logic [3:0] SP_C2  = 4'd5;  // *(2h1-h0)
	localparam logic [3:0] SP_NUM = 4'd6;  // s*(a+b+c)
	localparam logic [3:0] SP_DEN = 4'd7;  // h0*h1
	localparam logic [3:0] SP_TF  = 4'd8;  // first trapezoid
	localparam logic [3:0] SP_TL  = 4'd9;  // last trapezoid

	localparam int ACC_W = nsi_pkg::ACC_W;
	localparam int MP_W  = nsi_pkg::MP_W;
	localparam logic signed [ACC_W-1:0] SMAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SMIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [nsi_pkg::T_W-1:0] TRAP_HI =
		(nsi_pkg::T_W'(1) <<< nsi_pkg::TRAP_LIM) - nsi_pkg::T_W'(1);
	localparam logic signed [nsi_pkg::T_W-1:0] TRAP_LO =
		-(nsi_pkg::T_W'(1) <<< nsi_pkg::TRAP_LIM);

	function automatic logic sat65_ovf(input logic signed [ACC_W:0] v);
		return v[ACC_W] ^ v[ACC_W-1];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat65_val(input logic signed [ACC_W:0] v);
		logic signed [ACC_W-1:0] r;
		if (v[ACC_W] ^ v[ACC_W-1])
			r = v[ACC_W] ? SMIN : SMAX;
		else
			r = v[ACC_W-1:0];
		return r;
	endfunction

	logic [3:0]                          st_q, step_q;
	nsi_pkg::cmd_t                       cmd_q;
	logic signed [ACC_W-1:0]             even_sum_q, odd_sum_q, first_trap_q, tl_q, term_q;
	logic                                err_even_q, err_odd_q, fin_err_q;
	logic signed [nsi_pkg::T_W-1:0]      t_q;
	logic signed [nsi_pkg::MA_W-1:0]     acc_q;
	logic signed [nsi_pkg::NUM_W-1:0]    num_q;
	logic [nsi_pkg::DEN_W-1:0]           den_mag_q;
	logic                                den_neg_q;
	logic signed [ACC_W+1:0]             fsum_q;
	logic signed [ACC_W-1:0]             res_q;
	logic                                res_err_q;
	logic                                out_valid_q;
	logic signed [ACC_W-1:0]             integral_q;
	logic                                spacing_error_q;

	logic signed [32:0]                  h0, h1;
	logic signed [33:0]                  s;
	logic signed [34:0]                  p2, q2;
	logic signed [32:0]                  ff;
	logic                                mul_start, mul_done, div_start, div_done, div_ovf;
	logic signed [nsi_pkg::MA_W-1:0]     mul_a;
	logic signed [nsi_pkg::MB_W-1:0]     mul_b;
	logic signed [MP_W-1:0]              mul_p;
	logic [MP_W-1:0]                     p_mag;
	logic [nsi_pkg::DEN_W-1:0]           den6;
	logic signed [nsi_pkg::T_W-1:0]      tn;
	logic                                trap_ovf;
	logic signed [ACC_W-1:0]             trap_val;
	logic [nsi_pkg::NUM_W-1:0]           num_mag;
	logic [nsi_pkg::DIVN_W-1:0]          div_n;
	logic [nsi_pkg::Q_W-1:0]             div_q;
	logic                                term_neg, term_sat;
	logic signed [ACC_W-1:0]             term_val;
	logic signed [ACC_W:0]               acc_sum;
	logic signed [ACC_W+1:0]             half;
	logic                                half_ovf;
	logic signed [ACC_W-1:0]             half_val;
	logic                                emit_load;

	// interval widths of the current triple
	assign h0 = 33'(cmd_q.x1) - 33'(cmd_q.x0);
	assign h1 = 33'(cmd_q.x2) - 33'(cmd_q.x1);
	assign s  = 34'(h0) + 34'(h1);
	assign p2 = (35'(h0) <<< 1) - 35'(h1);
	assign q2 = (35'(h1) <<< 1) - 35'(h0);
	assign ff = 33'(cmd_q.f1) + 33'(cmd_q.f2);

	always_comb begin
		mul_a = nsi_pkg::MA_W'(h1);
		mul_b = nsi_pkg::MB_W'(ff);
		unique case (step_q)
			SP_A1:  begin mul_a = nsi_pkg::MA_W'(cmd_q.f0); mul_b = nsi_pkg::MB_W'(h1); end
			SP_A2:  begin mul_a = nsi_pkg::MA_W'(t_q);      mul_b = nsi_pkg::MB_W'(p2); end
			SP_B1:  begin mul_a = nsi_pkg::MA_W'(cmd_q.f1); mul_b = nsi_pkg::MB_W'(s);  end
			SP_B2:  begin mul_a = nsi_pkg::MA_W'(t_q);      mul_b = nsi_pkg::MB_W'(s);  end
			SP_C1:  begin mul_a = nsi_pkg::MA_W'(cmd_q.f2); mul_b = nsi_pkg::MB_W'(h0); end
			SP_C2:  begin mul_a = nsi_pkg::MA_W'(t_q);      mul_b = nsi_pkg::MB_W'(q2); end
			SP_NUM: begin mul_a = acc_q;                    mul_b = nsi_pkg::MB_W'(s);  end
			SP_DEN: begin mul_a = nsi_pkg::MA_W'(h0);       mul_b = nsi_pkg::MB_W'(h1); end
			default: begin mul_a = nsi_pkg::MA_W'(h1);      mul_b = nsi_pkg::MB_W'(ff); end
		endcase
	end

	assign mul_start = (st_q == ST_MUL_GO);
	assign div_start = (st_q == ST_DIV_GO);

	nsi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	// 6*|h0*h1|
	assign p_mag = mul_p[MP_W-1] ? MP_W'(-mul_p) : MP_W'(mul_p);
	assign den6  = {p_mag[nsi_pkg::DEN_W-3:0], 2'b00} + {p_mag[nsi_pkg::DEN_W-2:0], 1'b0};

	// trapezoid: product times 2^SCALE_SH / 2, saturated
	assign tn       = mul_p[nsi_pkg::T_W-1:0];
	assign trap_ovf = (tn > TRAP_HI) || (tn < TRAP_LO);
	assign trap_val = (tn > TRAP_HI) ? SMAX :
	                  (tn < TRAP_LO) ? SMIN : (ACC_W'(tn) <<< nsi_pkg::TRAP_SH);

	assign num_mag = num_q[nsi_pkg::NUM_W-1] ? nsi_pkg::NUM_W'(-num_q) : nsi_pkg::NUM_W'(num_q);
	assign div_n   = nsi_pkg::DIVN_W'(num_mag) << nsi_pkg::SCALE_SH;

	nsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (den_mag_q),
		.done   (div_done),
		.q      (div_q),
		.ovf    (div_ovf)
	);

	// signed, saturated quotient, truncated toward zero
	assign term_neg = num_q[nsi_pkg::NUM_W-1] ^ den_neg_q;
	always_comb begin
		term_sat = 1'b0;
		term_val = $signed(div_q);
		if (div_ovf) begin
			term_sat = 1'b1;
			term_val = term_neg ? SMIN : SMAX;
		end else if (!term_neg) begin
			if (div_q[ACC_W-1]) begin
				term_sat = 1'b1;
				term_val = SMAX;
			end
		end else if (div_q[ACC_W-1]) begin
			term_sat = |div_q[ACC_W-2:0];
			term_val = SMIN;
		end else begin
			term_val = -$signed(div_q);
		end
	end

	assign acc_sum = (cmd_q.odd_sum ? (ACC_W+1)'(odd_sum_q) : (ACC_W+1)'(even_sum_q))
	                 + (ACC_W+1)'(term_q);

	// final halving toward zero
	assign half     = fsum_q[ACC_W+1] ? ((fsum_q + (ACC_W+2)'(1)) >>> 1) : (fsum_q >>> 1);
	assign half_ovf = (half[ACC_W+1:ACC_W-1] != '0) && (half[ACC_W+1:ACC_W-1] != '1);
	assign half_val = half_ovf ? (half[ACC_W+1] ? SMIN : SMAX) : half[ACC_W-1:0];

	assign q_pop     = (st_q == ST_IDLE) && !q_empty;
	assign emit_load = (st_q == ST_EMIT) && (!out_valid_q || !out_stall);

	assign out_valid     = out_valid_q;
	assign integral      = integral_q;
	assign spacing_error = spacing_error_q;

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop)
			cmd_q <= q_head;
		if (mul_done) begin
			unique case (step_q)
				SP_A1, SP_B1, SP_C1: t_q <= mul_p[nsi_pkg::T_W-1:0];
				SP_A2:  acc_q <= mul_p[nsi_pkg::MA_W-1:0];
				SP_B2, SP_C2: acc_q <= acc_q + mul_p[nsi_pkg::MA_W-1:0];
				SP_NUM: num_q <= mul_p[nsi_pkg::NUM_W-1:0];
				SP_DEN: begin
					den_mag_q <= den6;
					den_neg_q <= mul_p[MP_W-1];
				end
				SP_TL:  tl_q <= trap_val;
				default: ;
			endcase
		end
		if (div_done)
			term_q <= term_val;
		unique case (st_q)
			ST_FIN1: fsum_q <= (ACC_W+2)'(even_sum_q) + (ACC_W+2)'(odd_sum_q);
			ST_FIN2: fsum_q <= fsum_q + (ACC_W+2)'(first_trap_q);
			ST_FIN3: fsum_q <= fsum_q + (ACC_W+2)'(tl_q);
			default: ;
		endcase
		if (emit_load) begin
			integral_q      <= res_q;
			spacing_error_q <= res_err_q;
		end
	end

	// sequencer and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			step_q       <= SP_A1;
			even_sum_q   <= '0;
			odd_sum_q    <= '0;
			first_trap_q <= '0;
			err_even_q   <= 1'b0;
			err_odd_q    <= 1'b0;
			fin_err_q    <= 1'b0;
			res_q        <= '0;
			res_err_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (st_q)
				ST_IDLE: begin
					if (!q_empty)
						st_q <= ST_DEC;
				end
				ST_DEC: begin
					unique case (cmd_q.op)
						nsi_pkg::OP_TRAP: begin
							step_q <= SP_TF;
							st_q   <= ST_MUL_GO;
						end
						nsi_pkg::OP_SIMP: begin
							if (h0 == '0 || h1 == '0) begin
								// zero-width triple: no term, flag its own sum
								if (cmd_q.odd_sum)
									err_odd_q <= 1'b1;
								else
									err_even_q <= 1'b1;
								st_q <= ST_END;
							end else begin
								step_q <= SP_A1;
								st_q   <= ST_MUL_GO;
							end
						end
						default: st_q <= ST_END;
					endcase
				end
				ST_MUL_GO: st_q <= ST_MUL_WAIT;
				ST_MUL_WAIT: begin
					if (mul_done) begin
						unique case (step_q)
							SP_DEN: st_q <= ST_DIV_GO;
							SP_TF: begin
								first_trap_q <= trap_val;
								err_odd_q    <= err_odd_q | trap_ovf;
								st_q         <= ST_END;
							end
							SP_TL: begin
								fin_err_q <= trap_ovf;
								st_q      <= ST_FIN1;
							end
							default: begin
								step_q <= step_q + 1'b1;
								st_q   <= ST_MUL_GO;
							end
						endcase
					end
				end
				ST_DIV_GO: st_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						if (cmd_q.odd_sum)
							err_odd_q <= err_odd_q | term_sat;
						else
							err_even_q <= err_even_q | term_sat;
						st_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (cmd_q.odd_sum) begin
						odd_sum_q <= sat65_val(acc_sum);
						err_odd_q <= err_odd_q | sat65_ovf(acc_sum);
					end else begin
						even_sum_q <= sat65_val(acc_sum);
						err_even_q <= err_even_q | sat65_ovf(acc_sum);
					end
					st_q <= ST_END;
				end
				ST_END: begin
					if (!cmd_q.last) begin
						st_q <= ST_IDLE;
					end else begin
						unique case (cmd_q.end_kind)
							nsi_pkg::END_EVEN: begin
								res_q     <= even_sum_q;
								res_err_q <= err_even_q;
								st_q      <= ST_EMIT;
							end
							nsi_pkg::END_HALF: begin
								step_q <= SP_TL;
								st_q   <= ST_MUL_GO;
							end
							default: begin
								res_q     <= '0;
								res_err_q <= 1'b0;
								st_q      <= ST_EMIT;
							end
						endcase
					end
				end
				ST_FIN1: st_q <= ST_FIN2;
				ST_FIN2: st_q <= ST_FIN3;
				ST_FIN3: st_q <= ST_FIN4;
				ST_FIN4: begin
					res_q     <= half_val;
					res_err_q <= half_ovf | fin_err_q | err_even_q | err_odd_q;
					st_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load) begin
						even_sum_q   <= '0;
						odd_sum_q    <= '0;
						first_trap_q <= '0;
						err_even_q   <= 1'b0;
						err_odd_q    <= 1'b0;
						st_q         <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV_GO) |-> (den_mag_q != '0))
		else $error("divide started with zero denominator");

	a_line_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |=> (even_sum_q == '0 && odd_sum_q == '0 && !err_even_q && !err_odd_q))
		else $error("line state not cleared after result");

	a_mul_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (st_q == ST_MUL_WAIT))
		else $error("multiplier finished outside its wait state");

endmodule

// File: hdl/nonuniform_simpson_integrator_top.sv
// ----------------------------------------------------------------------------
// nonuniform_simpson_integrator_top: composite Simpson rule on a non-uniform grid
// Streams (coord, sample) requests of one line and returns the line integral
// in Q32.32 with a spacing/saturation error flag after the request marked last.
// ----------------------------------------------------------------------------
// Flow: a request is taken whenever the two-entry command queue has room,
// so the intake waits for arithmetic in progress only when the queue is
// full. The back end works one command at a time on a single shift-and-add
// multiplier (one multiplier bit per cycle, stopping early on short
// operands; multipliers are at most 34 bits) and a restoring divider (one
// quotient bit per cycle). The first sample of a line needs no arithmetic,
// the second one trapezoid multiply, and every further sample a Simpson
// term of eight multiplies plus one divide, its length depending on the bit
// lengths of the widths and their sums; the request marked last can add the
// closing trapezoid and halving.
// The result sits in an output register, so the next line is accepted while
// a finished result is still waiting to be taken. skip_first_sample (written
// through cfg_wr_en/cfg_wr_data while the block is idle) drops the first
// sample of every following line. A zero-width interval in a used triple or
// a saturated value raises spacing_error; sums saturate instead of wrapping.
module nonuniform_simpson_integrator_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic                             cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [nsi_pkg::X_W-1:0]   coord,
	input  logic signed [nsi_pkg::X_W-1:0]   sample,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [nsi_pkg::ACC_W-1:0] integral,
	output logic                             spacing_error
);

	// front end -> queue
	logic          push, full;
	nsi_pkg::cmd_t push_cmd;
	// queue -> back end
	logic          pop, empty;
	nsi_pkg::cmd_t head;

	// classifies each request: drop, first sample, first interval,
	// or a closing Simpson triple for the even or odd sum
	nsi_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.coord       (coord),
		.sample      (sample),
		.last        (last),
		.q_push      (push),
		.q_cmd       (push_cmd),
		.q_full      (full)
	);

	// decouples intake from the long arithmetic sequence
	nsi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	// terms, sums, end-of-line combine and the output register
	nsi_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (empty),
		.q_head        (head),
		.q_pop         (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.integral      (integral),
		.spacing_error (spacing_error)
	);

endmodule

// File: verif/nsi_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsi_line_checker: line integral predictor and result checker
// Follows every accepted request and config write, predicts the integral and
// error flag of each line and compares them with the accepted results.
// ----------------------------------------------------------------------------
module nsi_line_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] coord,
	input  logic [31:0] sample,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] integral,
	input  logic        spacing_error,
	output int          fail_count,
	output int          lines_pending,
	output int          lines_checked
);

	typedef logic signed [191:0] wide_t;

	typedef struct {
		logic signed [63:0] value;
		logic               err;
	} line_result_t;

	localparam wide_t I64_MAX = 192'sh7FFF_FFFF_FFFF_FFFF;
	localparam wide_t I64_MIN = -I64_MAX - 192'sd1;

	line_result_t expected_lines[$];

	logic               skip_mode;
	wide_t              hist_x[2];
	wide_t              hist_f[2];
	logic signed [63:0] even_sum, odd_sum, head_trap;
	logic [31:0]        kept;
	logic               even_err, odd_err, head_dropped;

	// saturate to the 64-bit range, an exact minimum is not an overflow
	function automatic logic signed [63:0] clamp64(input wide_t v, inout logic flag);
		if (v > I64_MAX) begin
			flag = 1'b1;
			return I64_MAX[63:0];
		end
		if (v < I64_MIN) begin
			flag = 1'b1;
			return I64_MIN[63:0];
		end
		return v[63:0];
	endfunction

	// Q(2*FRAC) product over divisor, rescaled to Q32.32, truncated toward zero
	function automatic logic signed [63:0] rescale_div(input wide_t n, input wide_t d,
			inout logic flag);
		wide_t q;
		q = (n <<< nsi_pkg::SCALE_SH) / d;
		return clamp64(q, flag);
	endfunction

	function automatic logic signed [63:0] trap_area(input wide_t xa, fa, xb, fb,
			inout logic flag);
		return rescale_div((xb - xa) * (fa + fb), 192'sd2, flag);
	endfunction

	function automatic logic signed [63:0] simpson_area(input wide_t x2, f2, inout logic flag);
		wide_t h0, h1, s, a, b, c;
		h0 = hist_x[1] - hist_x[0];
		h1 = x2 - hist_x[1];
		s  = h0 + h1;
		if (h0 == 0 || h1 == 0) begin
			flag = 1'b1;
			return 64'sd0;
		end
		a = hist_f[0] * h1 * (192'sd2 * h0 - h1);
		b = hist_f[1] * s * s;
		c = f2 * h0 * (192'sd2 * h1 - h0);
		return rescale_div(s * (a + b + c), 192'sd6 * h0 * h1, flag);
	endfunction

	task automatic clear_line();
		hist_x = '{default: '0};
		hist_f = '{default: '0};
		even_sum = '0;
		odd_sum = '0;
		head_trap = '0;
		kept = '0;
		even_err = 1'b0;
		odd_err = 1'b0;
		head_dropped = 1'b0;
	endtask

	task automatic take_request(input logic [31:0] xr, fr, input logic is_last);
		wide_t              x, f, total;
		logic [31:0]        k;
		logic signed [63:0] t;
		line_result_t       res;
		x = wide_t'($signed(xr));
		f = wide_t'($signed(fr));
		k = kept;
		res.value = '0;
		res.err = 1'b0;
		if (skip_mode && k == 0 && !head_dropped) begin
			head_dropped = 1'b1;
			if (is_last) begin
				clear_line();
				expected_lines.push_back(res);
			end
			return;
		end
		if (k >= 2) begin
			if (!k[0]) begin
				t = simpson_area(x, f, even_err);
				even_sum = clamp64(wide_t'(even_sum) + wide_t'(t), even_err);
			end else begin
				t = simpson_area(x, f, odd_err);
				odd_sum = clamp64(wide_t'(odd_sum) + wide_t'(t), odd_err);
			end
		end else if (k == 1) begin
			head_trap = trap_area(hist_x[1], hist_f[1], x, f, odd_err);
		end
		hist_x[0] = hist_x[1];
		hist_f[0] = hist_f[1];
		hist_x[1] = x;
		hist_f[1] = f;
		kept = (k == 32'hFFFF_FFFF) ? 32'd2 : k + 32'd1;
		if (!is_last)
			return;
		if (!k[0]) begin
			// odd number of kept samples: even sum only
			if (k != 0) begin
				res.value = even_sum;
				res.err = even_err;
			end
		end else begin
			t = trap_area(hist_x[0], hist_f[0], hist_x[1], hist_f[1], res.err);
			total = wide_t'(even_sum) + wide_t'(odd_sum) + wide_t'(head_trap) + wide_t'(t);
			res.value = clamp64(total / 192'sd2, res.err);
			res.err = res.err | even_err | odd_err;
		end
		clear_line();
		expected_lines.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_result_t want;
		if (!arst_n) begin
			skip_mode <= 1'b0;
			clear_line();
			expected_lines.delete();
			fail_count <= 0;
			lines_checked <= 0;
		end else begin
			if (cfg_wr_en)
				skip_mode <= cfg_wr_data;
			if (in_valid && !in_stall)
				take_request(coord, sample, last);
			if (out_valid && !out_stall) begin
				lines_checked <= lines_checked + 1;
				if (expected_lines.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: integral %h error %b",
							integral, spacing_error);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_lines.pop_front();
					if (integral !== want.value || spacing_error !== want.err) begin
						if (fail_count < 10)
							$display("mismatch: integral exp %h got %h, error exp %b got %b",
								want.value, integral, want.err, spacing_error);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

	assign lines_pending = expected_lines.size();

endmodule

// File: verif/nonuniform_simpson_integrator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonuniform_simpson_integrator_top_test: testbench of the Simpson integrator
// Drives directed and random lines of requests under several idle/stall
// mixes and both skip_first_sample settings; a checker predicts each line.
// ----------------------------------------------------------------------------
module nonuniform_simpson_integrator_top_test;

	localparam int WATCHDOG_LIMIT = 20000;  // far above one Simpson term plus stalls
	localparam int DRAIN_CYCLES   = 500;    // longest request plus closing work

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] coord = '0;
	logic [31:0] sample = '0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] integral;
	logic        spacing_error;

	int fail_count, lines_pending, lines_checked;
	int idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	nonuniform_simpson_integrator_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.coord        (coord),
		.sample       (sample),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.integral     (integral),
		.spacing_error(spacing_error)
	);

	nsi_line_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.coord        (coord),
		.sample       (sample),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.integral     (integral),
		.spacing_error(spacing_error),
		.fail_count   (fail_count),
		.lines_pending(lines_pending),
		.lines_checked(lines_checked)
	);

	// receiver back-pressure, random per cycle at the phase's rate
	always @(posedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// watchdog: cycles in which neither channel moves a request or result
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d lines still open", lines_pending);
			$display("simulation failed");
			$finish;
		end
	end

	// one request; valid stays up across back-to-back requests
	task automatic push_request(input logic [31:0] x, f, input logic is_last);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		coord <= x;
		sample <= f;
		last <= is_last;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// config is only touched with all lines finished and the back end quiet
	task automatic write_skip(input logic v);
		in_valid <= 1'b0;
		do @(posedge clk); while (lines_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// one line: mostly increasing grids with random spacing scale,
	// sometimes zero steps or fully random coordinates
	task automatic send_line(input int n, input bit noisy);
		logic [31:0] x, f, mask;
		int i;
		x = $urandom;
		mask = 32'hFFFF_FFFF >> $urandom_range(1, 28);
		for (i = 0; i < n; i++) begin
			f = $urandom;
			if ($urandom_range(1))
				f = $signed(f) >>> $urandom_range(0, 30);
			push_request(x, f, i == n - 1);
			if (noisy)
				x = $urandom;
			else if ($urandom_range(19) != 0)
				x = x + (($urandom & mask) | 32'd1);
		end
	endtask

	initial begin
		int phase;
		int goal;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines
		write_skip(1'b0);
		push_request(32'd0, 32'h7FFF_FFFF, 1'b1);                 // single sample
		push_request(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);         // two, saturating
		push_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		push_request(32'h0000_0000, 32'h0001_0000, 1'b0);         // uniform triple
		push_request(32'h0001_0000, 32'h0002_0000, 1'b0);
		push_request(32'h0002_0000, 32'h0003_0000, 1'b1);
		push_request(32'd5, 32'd1, 1'b0);                         // zero-width interval
		push_request(32'd5, 32'd2, 1'b0);
		push_request(32'd9, 32'd3, 1'b0);
		push_request(32'd12, 32'd4, 1'b1);
		push_request(32'h0064_0000, 32'hFFFF_FFFF, 1'b0);         // decreasing grid
		push_request(32'h0032_0000, 32'h8000_0000, 1'b0);
		push_request(32'h0000_0000, 32'h8000_0000, 1'b1);
		push_request(32'h8000_0000, 32'h8000_0000, 1'b0);         // extreme values
		push_request(32'hC000_0000, 32'h7FFF_FFFF, 1'b0);
		push_request(32'h0000_0001, 32'h8000_0000, 1'b0);
		push_request(32'h4000_0000, 32'h7FFF_FFFF, 1'b0);
		push_request(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		write_skip(1'b1);
		push_request(32'h0000_1000, 32'h1234_5678, 1'b1);         // only sample dropped
		push_request(32'h0000_0000, 32'h7FFF_FFFF, 1'b0);         // dropped, then a pair
		push_request(32'h0001_0000, 32'h0001_0000, 1'b0);
		push_request(32'h0003_0000, 32'hFFFF_0000, 1'b1);

		// random lines: no idling, idle sender, stalling receiver, both
		goal = items_sent;
		for (phase = 0; phase < 4; phase++) begin
			write_skip(phase == 1 || phase == 2);
			idle_pct  = (phase == 1) ? 86 : (phase == 3) ? 16 : 0;
			stall_pct = (phase == 2) ? 86 : (phase == 3) ? 16 : 0;
			goal += 332;
			while (items_sent < goal) begin
				if ($urandom_range(9) == 0)
					send_line($urandom_range(1, 30), $urandom_range(3) == 0);
				else
					send_line($urandom_range(1, 8), 1'b0);
			end
		end
		in_valid <= 1'b0;
		idle_pct = 0;

		do @(posedge clk); while (lines_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d requests sent, %0d line results checked", items_sent, lines_checked);
		$display("covered both skip settings under four idle/stall mixes");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
